### hdl/bmt_pkg.sv
// Shared constants, types and the operator decoder of the bracket matching tokenizer.
package bmt_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int INDEX_BITS  = 16;
    localparam int COUNT_BITS  = 8;
    localparam int MAX_RESULTS = 40;
    localparam int RCNT_BITS   = 6;

    // record kinds
    localparam logic [1:0] KIND_INSTR = 2'd0;
    localparam logic [1:0] KIND_PATCH = 2'd1;
    localparam logic [1:0] KIND_ERR   = 2'd2;

    // error codes
    localparam logic [3:0] ERR_STRAY_LOOP  = 4'd1;
    localparam logic [3:0] ERR_LOOP_CROSS  = 4'd2;
    localparam logic [3:0] ERR_FUNC_CROSS  = 4'd3;
    localparam logic [3:0] ERR_STRAY_FUNC  = 4'd4;
    localparam logic [3:0] ERR_BAD_SWITCH  = 4'd5;
    localparam logic [3:0] ERR_OPEN_LOOP   = 4'd6;
    localparam logic [3:0] ERR_OPEN_FUNC   = 4'd7;
    localparam logic [3:0] ERR_OVERFLOW    = 4'd8;
    localparam logic [3:0] ERR_EMPTY       = 4'd9;

    // dialects and register indexes
    localparam logic [1:0] DIA_THREAD = 2'd0;
    localparam logic [1:0] DIA_PROC   = 2'd1;
    localparam logic [1:0] DIA_FORK   = 2'd2;
    localparam logic       CFG_DIALECT = 1'b0;
    localparam logic       CFG_OPT     = 1'b1;

    // op codes
    localparam logic [5:0] OP_LEFT        = 6'd0;
    localparam logic [5:0] OP_RIGHT       = 6'd1;
    localparam logic [5:0] OP_INC         = 6'd2;
    localparam logic [5:0] OP_DEC         = 6'd3;
    localparam logic [5:0] OP_OUT         = 6'd4;
    localparam logic [5:0] OP_IN          = 6'd5;
    localparam logic [5:0] OP_OPEN_LOOP   = 6'd6;
    localparam logic [5:0] OP_CLOSE_LOOP  = 6'd7;
    localparam logic [5:0] OP_FORK        = 6'd8;
    localparam logic [5:0] OP_JOIN        = 6'd9;
    localparam logic [5:0] OP_TERM        = 6'd10;
    localparam logic [5:0] OP_OPEN_FUNC   = 6'd11;
    localparam logic [5:0] OP_CLOSE_FUNC  = 6'd12;
    localparam logic [5:0] OP_CALL        = 6'd13;
    localparam logic [5:0] OP_PUSH        = 6'd14;
    localparam logic [5:0] OP_POP         = 6'd15;
    localparam logic [5:0] OP_SWAP        = 6'd16;
    localparam logic [5:0] OP_DEC_WRITE   = 6'd17;
    localparam logic [5:0] OP_DEC_READ    = 6'd18;
    localparam logic [5:0] OP_SHARED_PUSH = 6'd19;
    localparam logic [5:0] OP_SET_ZERO    = 6'd22;
    localparam logic [5:0] OP_RUN_BASE    = 6'd23;
    localparam logic [5:0] OP_END_PROGRAM = 6'd27;
    localparam logic [5:0] OP_DUMP_SIMPLE = 6'd28;
    localparam logic [5:0] OP_DUMP_MEM    = 6'd29;
    localparam logic [5:0] OP_DUMP_FSTACK = 6'd30;
    localparam logic [5:0] OP_DUMP_FDEFS  = 6'd31;
    localparam logic [5:0] OP_DUMP_STACK  = 6'd32;
    localparam logic [5:0] OP_DUMP_SHARED = 6'd33;
    localparam logic [5:0] OP_DUMP_THREAD = 6'd34;
    localparam logic [5:0] OP_SWITCH      = 6'd60;
    localparam logic [5:0] OP_PRAGMA      = 6'd61;
    localparam logic [5:0] OP_NONE        = 6'd63;

    typedef enum logic [2:0] {IDX_CNT, IDX_POS, IDX_LTOP, IDX_FTOP, IDX_ZERO} idx_sel_t;
    typedef enum logic [1:0] {JT_ZERO, JT_POS, JT_LTOP, JT_FTOP} jt_sel_t;
    typedef enum logic [1:0] {CUR_ITEM, CUR_OPEN, CUR_DEC} cur_sel_t;

    typedef struct packed {
        logic       emit;
        logic [1:0] kind;
        logic [5:0] op;
        idx_sel_t   idx_sel;
        jt_sel_t    jt_sel;
        logic       rep_run;
        logic [3:0] err;
        logic       last;
        logic       set_seen;
        logic       zl_wr;
        logic [1:0] zl_val;
        logic       sh_wr;
        logic       sh_val;
        logic       run_start;
        logic       run_inc;
        logic       run_clr;
        logic       push_loop;
        logic       push_func;
        logic       pop_loop;
        logic       pop_func;
        logic       pos_ld;
        logic       cur_ld;
        cur_sel_t   cur_sel;
        logic       clear;
    } cmd_t;

    typedef struct packed {
        logic       cv;
        logic       eos;
        logic [5:0] item_op;
        logic [5:0] cur_op;
        logic [5:0] run_op;
        logic       run_busy;
        logic       run_full;
        logic [1:0] zl;
        logic       shared;
        logic       seen;
        logic       fold;
        logic       loop_empty;
        logic       loop_full;
        logic       func_empty;
        logic       func_full;
        logic       loop_cross;
        logic       func_cross;
        logic       out_free;
    } stat_t;

    function automatic logic [5:0] classify(input logic [7:0] c, input logic [1:0] dia,
                                            input logic dbg);
        logic [5:0] op;
        op = OP_NONE;
        case (c)
            "<": op = OP_LEFT;
            ">": op = OP_RIGHT;
            "+": op = OP_INC;
            "-": op = OP_DEC;
            ".": op = OP_OUT;
            ",": op = OP_IN;
            "[": op = OP_OPEN_LOOP;
            "]": op = OP_CLOSE_LOOP;
            default: begin
                case (dia)
                    DIA_THREAD: begin
                        case (c)
                            "{": op = OP_FORK;
                            "}": op = OP_JOIN;
                            "!": op = OP_TERM;
                            "(": op = OP_OPEN_FUNC;
                            ")": op = OP_CLOSE_FUNC;
                            "*": op = OP_CALL;
                            "&": op = OP_PUSH;
                            "^": op = OP_POP;
                            "%": op = OP_SWAP;
                            "~": op = OP_SWITCH;
                            ":": op = OP_DEC_WRITE;
                            ";": op = OP_DEC_READ;
                            default: op = OP_NONE;
                        endcase
                        if (dbg && op == OP_NONE) begin
                            case (c)
                                "M": op = OP_DUMP_SIMPLE;
                                "D": op = OP_DUMP_MEM;
                                "F": op = OP_DUMP_FSTACK;
                                "E": op = OP_DUMP_FDEFS;
                                "S": op = OP_DUMP_STACK;
                                "H": op = OP_DUMP_SHARED;
                                "T": op = OP_DUMP_THREAD;
                                "#": op = OP_PRAGMA;
                                default: op = OP_NONE;
                            endcase
                        end
                    end
                    DIA_PROC: begin
                        case (c)
                            "(": op = OP_OPEN_FUNC;
                            ")": op = OP_CLOSE_FUNC;
                            ":": op = OP_CALL;
                            "M": op = dbg ? OP_DUMP_SIMPLE : OP_NONE;
                            "D": op = dbg ? OP_DUMP_MEM : OP_NONE;
                            "F": op = dbg ? OP_DUMP_FSTACK : OP_NONE;
                            "E": op = dbg ? OP_DUMP_FDEFS : OP_NONE;
                            default: op = OP_NONE;
                        endcase
                    end
                    DIA_FORK: begin
                        case (c)
                            "Y": op = OP_FORK;
                            "M": op = dbg ? OP_DUMP_SIMPLE : OP_NONE;
                            "D": op = dbg ? OP_DUMP_MEM : OP_NONE;
                            "T": op = dbg ? OP_DUMP_THREAD : OP_NONE;
                            default: op = OP_NONE;
                        endcase
                    end
                    default: begin
                        case (c)
                            "#", "M": op = dbg ? OP_DUMP_SIMPLE : OP_NONE;
                            "D": op = dbg ? OP_DUMP_MEM : OP_NONE;
                            default: op = OP_NONE;
                        endcase
                    end
                endcase
            end
        endcase
        return op;
    endfunction

endpackage

### hdl/bmt_dp.sv
// Datapath of the bracket matching tokenizer: item, program state, stacks and result register.
module bmt_dp #(
    parameter int STACK_DEPTH = bmt_pkg::STACK_DEPTH,
    parameter int INDEX_BITS  = bmt_pkg::INDEX_BITS,
    parameter int COUNT_BITS  = bmt_pkg::COUNT_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  logic                  in_cv,
    input  logic [7:0]            in_char,
    input  logic                  in_eos,
    input  logic                  cfg_we,
    input  logic                  cfg_idx,
    input  logic [1:0]            cfg_val,
    input  bmt_pkg::cmd_t         cmd,
    output bmt_pkg::stat_t        stat,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [1:0]            out_kind,
    output logic [5:0]            out_op,
    output logic [INDEX_BITS-1:0] out_idx,
    output logic [INDEX_BITS-1:0] out_jt,
    output logic [COUNT_BITS-1:0] out_rep,
    output logic [3:0]            out_err,
    output logic                  out_ok,
    output logic                  out_last
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW = $clog2(STACK_DEPTH + 1);

    logic [1:0]            dialect_reg, opt_reg;
    logic                  cv_reg, eos_reg;
    logic [7:0]            char_reg;
    logic [5:0]            cur_reg, run_op_reg;
    logic [COUNT_BITS-1:0] run_cnt_reg;
    logic [1:0]            zl_reg;
    logic                  sh_reg, seen_reg, ok_reg;
    logic [INDEX_BITS-1:0] cnt_reg, pos_reg;
    logic [DW-1:0]         ldep_reg, fdep_reg, ldm1, fdm1;
    logic [INDEX_BITS-1:0] loop_mem [STACK_DEPTH];
    logic [INDEX_BITS-1:0] func_mem [STACK_DEPTH];
    logic [INDEX_BITS-1:0] loop_rd_reg, func_rd_reg;
    logic [RCNT_W-1:0]     rcnt_reg;
    logic [5:0]            item_op;
    logic [INDEX_BITS-1:0] idx_val, jt_val;
    logic                  out_free;

    localparam int RCNT_W = bmt_pkg::RCNT_BITS;

    assign item_op  = bmt_pkg::classify(char_reg, dialect_reg, opt_reg == 2'd0);
    assign ldm1     = ldep_reg - DW'(1);
    assign fdm1     = fdep_reg - DW'(1);
    assign out_free = !out_valid || out_ready;

    always_comb begin
        stat            = '0;
        stat.cv         = cv_reg;
        stat.eos        = eos_reg;
        stat.item_op    = item_op;
        stat.cur_op     = cur_reg;
        stat.run_op     = run_op_reg;
        stat.run_busy   = run_cnt_reg != '0;
        stat.run_full   = run_cnt_reg == {COUNT_BITS{1'b1}};
        stat.zl         = zl_reg;
        stat.shared     = sh_reg;
        stat.seen       = seen_reg;
        stat.fold       = opt_reg[1];
        stat.loop_empty = ldep_reg == '0;
        stat.loop_full  = ldep_reg == DW'(STACK_DEPTH);
        stat.func_empty = fdep_reg == '0;
        stat.func_full  = fdep_reg == DW'(STACK_DEPTH);
        stat.loop_cross = (fdep_reg != '0) && (loop_rd_reg < func_rd_reg);
        stat.func_cross = (ldep_reg != '0) && (func_rd_reg < loop_rd_reg);
        stat.out_free   = out_free;
    end

    always_comb begin
        case (cmd.idx_sel)
            bmt_pkg::IDX_CNT:  idx_val = cnt_reg;
            bmt_pkg::IDX_POS:  idx_val = pos_reg;
            bmt_pkg::IDX_LTOP: idx_val = loop_rd_reg;
            bmt_pkg::IDX_FTOP: idx_val = func_rd_reg;
            default:           idx_val = '0;
        endcase
        case (cmd.jt_sel)
            bmt_pkg::JT_POS:  jt_val = pos_reg;
            bmt_pkg::JT_LTOP: jt_val = loop_rd_reg;
            bmt_pkg::JT_FTOP: jt_val = func_rd_reg;
            default:          jt_val = '0;
        endcase
    end

    // stack memories, top entry read every cycle
    always_ff @(posedge aclk) begin
        if (cmd.push_loop) loop_mem[ldep_reg[AW-1:0]] <= cnt_reg;
        if (cmd.push_func) func_mem[fdep_reg[AW-1:0]] <= cnt_reg;
        loop_rd_reg <= loop_mem[ldm1[AW-1:0]];
        func_rd_reg <= func_mem[fdm1[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cv_reg   <= in_cv;
            char_reg <= in_char;
            eos_reg  <= in_eos;
        end
        if (cmd.pos_ld) pos_reg <= cnt_reg;
        if (cmd.cur_ld) begin
            case (cmd.cur_sel)
                bmt_pkg::CUR_OPEN: cur_reg <= bmt_pkg::OP_OPEN_LOOP;
                bmt_pkg::CUR_DEC:  cur_reg <= bmt_pkg::OP_DEC;
                default:           cur_reg <= item_op;
            endcase
        end
        if (cmd.run_start) run_op_reg <= cur_reg;
        if (cmd.emit && rcnt_reg < RCNT_W'(bmt_pkg::MAX_RESULTS)) begin
            out_kind <= cmd.kind;
            out_op   <= cmd.op;
            out_idx  <= idx_val;
            out_jt   <= jt_val;
            out_rep  <= cmd.rep_run ? run_cnt_reg : COUNT_BITS'(1);
            out_err  <= cmd.err;
            out_ok   <= (cmd.kind == bmt_pkg::KIND_ERR) ? 1'b0 : ok_reg;
            out_last <= cmd.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dialect_reg <= bmt_pkg::DIA_THREAD;
            opt_reg     <= 2'd1;
            run_cnt_reg <= '0;
            zl_reg      <= '0;
            sh_reg      <= 1'b0;
            seen_reg    <= 1'b0;
            ok_reg      <= 1'b1;
            cnt_reg     <= '0;
            ldep_reg    <= '0;
            fdep_reg    <= '0;
            rcnt_reg    <= '0;
            out_valid   <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_idx == bmt_pkg::CFG_DIALECT) dialect_reg <= cfg_val;
                else                                 opt_reg     <= cfg_val;
            end
            if (accept) rcnt_reg <= '0;
            if (cmd.emit) begin
                if (rcnt_reg < RCNT_W'(bmt_pkg::MAX_RESULTS)) rcnt_reg <= rcnt_reg + RCNT_W'(1);
                if (cmd.kind == bmt_pkg::KIND_INSTR) cnt_reg <= cnt_reg + INDEX_BITS'(1);
                if (cmd.kind == bmt_pkg::KIND_ERR)   ok_reg  <= 1'b0;
            end
            if (cmd.emit && rcnt_reg < RCNT_W'(bmt_pkg::MAX_RESULTS)) out_valid <= 1'b1;
            else if (out_ready)                                        out_valid <= 1'b0;
            if (cmd.set_seen) seen_reg <= 1'b1;
            if (cmd.zl_wr)    zl_reg   <= cmd.zl_val;
            if (cmd.sh_wr)    sh_reg   <= cmd.sh_val;
            if (cmd.run_start)    run_cnt_reg <= COUNT_BITS'(1);
            else if (cmd.run_inc) run_cnt_reg <= run_cnt_reg + COUNT_BITS'(1);
            else if (cmd.run_clr) run_cnt_reg <= '0;
            if (cmd.push_loop)     ldep_reg <= ldep_reg + DW'(1);
            else if (cmd.pop_loop) ldep_reg <= ldm1;
            if (cmd.push_func)     fdep_reg <= fdep_reg + DW'(1);
            else if (cmd.pop_func) fdep_reg <= fdm1;
            if (cmd.clear) begin
                run_cnt_reg <= '0;
                zl_reg      <= '0;
                sh_reg      <= 1'b0;
                seen_reg    <= 1'b0;
                ok_reg      <= 1'b1;
                cnt_reg     <= '0;
                ldep_reg    <= '0;
                fdep_reg    <= '0;
            end
        end
    end

endmodule

### hdl/bmt_ctrl.sv
// Controller of the bracket matching tokenizer: sequences feed, bracket handling and end of program.
module bmt_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           accept,
    input  bmt_pkg::stat_t stat,
    output bmt_pkg::cmd_t  cmd,
    output logic           in_ready
);

    typedef enum logic [14:0] {
        S_IDLE   = 15'b000000000000001,
        S_FEED   = 15'b000000000000010,
        S_RUNCHK = 15'b000000000000100,
        S_MAIN   = 15'b000000000001000,
        S_DISP   = 15'b000000000010000,
        S_CLA    = 15'b000000000100000,
        S_CLB    = 15'b000000001000000,
        S_HERR   = 15'b000000010000000,
        S_FIN    = 15'b000000100000000,
        S_FLUSH  = 15'b000001000000000,
        S_UNLW   = 15'b000010000000000,
        S_UNL    = 15'b000100000000000,
        S_UNFW   = 15'b001000000000000,
        S_UNF    = 15'b010000000000000,
        S_ENDP   = 15'b100000000000000
    } state_t;

    state_t        state_reg, state_next, after_st;
    logic [1:0]    held_reg, held_next;
    logic          ret_res_reg, ret_res_next;
    logic          fin_reg, fin_next;
    logic [3:0]    err_reg, err_next;
    logic          hdone, is_loop;
    bmt_pkg::cmd_t c;

    assign in_ready = state_reg == S_IDLE;
    assign after_st = stat.eos ? S_FIN : S_IDLE;
    assign is_loop  = stat.cur_op == bmt_pkg::OP_CLOSE_LOOP;

    always_comb begin
        c            = '0;
        hdone        = 1'b0;
        state_next   = state_reg;
        held_next    = held_reg;
        ret_res_next = ret_res_reg;
        fin_next     = fin_reg;
        err_next     = err_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    fin_next   = 1'b0;
                    state_next = S_FEED;
                end
            end
            S_FEED: begin
                if (!stat.cv) begin
                    state_next = after_st;
                end else begin
                    c.set_seen = 1'b1;
                    if (stat.zl == 2'd1 && stat.item_op == bmt_pkg::OP_DEC) begin
                        c.zl_wr    = 1'b1;
                        c.zl_val   = 2'd2;
                        state_next = after_st;
                    end else if (stat.zl == 2'd2 && stat.item_op == bmt_pkg::OP_CLOSE_LOOP) begin
                        c.zl_wr    = 1'b1;
                        c.emit     = 1'b1;
                        c.op       = bmt_pkg::OP_SET_ZERO;
                        state_next = after_st;
                    end else if (stat.zl != 2'd0) begin
                        held_next    = stat.zl;
                        c.zl_wr      = 1'b1;
                        c.cur_ld     = 1'b1;
                        c.cur_sel    = bmt_pkg::CUR_OPEN;
                        ret_res_next = 1'b1;
                        state_next   = S_DISP;
                    end else begin
                        state_next = S_RUNCHK;
                    end
                end
            end
            S_RUNCHK: begin
                if (stat.run_busy && stat.item_op == stat.run_op && !stat.run_full) begin
                    c.run_inc  = 1'b1;
                    state_next = after_st;
                end else begin
                    if (stat.run_busy) begin
                        c.emit    = 1'b1;
                        c.op      = bmt_pkg::OP_RUN_BASE + {4'd0, stat.run_op[1:0]};
                        c.rep_run = 1'b1;
                        c.run_clr = 1'b1;
                    end
                    state_next = S_MAIN;
                end
            end
            S_MAIN: begin
                if (stat.item_op == bmt_pkg::OP_NONE) begin
                    state_next = after_st;
                end else if (stat.fold && stat.item_op == bmt_pkg::OP_OPEN_LOOP) begin
                    c.zl_wr    = 1'b1;
                    c.zl_val   = 2'd1;
                    state_next = after_st;
                end else begin
                    c.cur_ld     = 1'b1;
                    c.cur_sel    = bmt_pkg::CUR_ITEM;
                    ret_res_next = 1'b0;
                    state_next   = S_DISP;
                end
            end
            S_DISP: begin
                c.pos_ld = 1'b1;
                case (stat.cur_op)
                    bmt_pkg::OP_OPEN_LOOP, bmt_pkg::OP_OPEN_FUNC: begin
                        c.emit = 1'b1;
                        c.op   = stat.cur_op;
                        if (stat.cur_op == bmt_pkg::OP_OPEN_LOOP ? stat.loop_full
                                                                  : stat.func_full) begin
                            err_next   = bmt_pkg::ERR_OVERFLOW;
                            state_next = S_HERR;
                        end else begin
                            c.push_loop = stat.cur_op == bmt_pkg::OP_OPEN_LOOP;
                            c.push_func = stat.cur_op == bmt_pkg::OP_OPEN_FUNC;
                            hdone       = 1'b1;
                        end
                    end
                    bmt_pkg::OP_CLOSE_LOOP, bmt_pkg::OP_CLOSE_FUNC: begin
                        if (is_loop ? stat.loop_empty : stat.func_empty) begin
                            c.emit = 1'b1;
                            c.kind = bmt_pkg::KIND_ERR;
                            c.err  = is_loop ? bmt_pkg::ERR_STRAY_LOOP : bmt_pkg::ERR_STRAY_FUNC;
                            hdone  = 1'b1;
                        end else begin
                            state_next = S_CLA;
                        end
                    end
                    bmt_pkg::OP_SWITCH: begin
                        c.sh_wr  = 1'b1;
                        c.sh_val = 1'b1;
                        hdone    = 1'b1;
                    end
                    default: begin
                        hdone = 1'b1;
                        c.emit = 1'b1;
                        c.op   = stat.cur_op;
                        if (stat.shared) begin
                            c.sh_wr = 1'b1;
                            if (stat.cur_op inside {bmt_pkg::OP_PUSH, bmt_pkg::OP_POP,
                                                    bmt_pkg::OP_SWAP}) begin
                                c.op = bmt_pkg::OP_SHARED_PUSH + (stat.cur_op - bmt_pkg::OP_PUSH);
                            end else begin
                                c.op   = '0;
                                c.kind = bmt_pkg::KIND_ERR;
                                c.err  = bmt_pkg::ERR_BAD_SWITCH;
                            end
                        end else if (stat.cur_op == bmt_pkg::OP_PRAGMA) begin
                            c.op   = '0;
                            c.kind = bmt_pkg::KIND_ERR;
                            c.err  = bmt_pkg::ERR_OVERFLOW;
                        end else if (stat.fold && stat.cur_op <= bmt_pkg::OP_DEC) begin
                            c.emit      = 1'b0;
                            c.run_start = 1'b1;
                        end
                    end
                endcase
            end
            S_CLA: begin
                // patch record for the opening bracket
                c.emit     = 1'b1;
                c.kind     = bmt_pkg::KIND_PATCH;
                c.op       = is_loop ? bmt_pkg::OP_OPEN_LOOP : bmt_pkg::OP_OPEN_FUNC;
                c.idx_sel  = is_loop ? bmt_pkg::IDX_LTOP : bmt_pkg::IDX_FTOP;
                c.jt_sel   = bmt_pkg::JT_POS;
                state_next = S_CLB;
            end
            S_CLB: begin
                c.emit     = 1'b1;
                c.op       = stat.cur_op;
                c.jt_sel   = is_loop ? bmt_pkg::JT_LTOP : bmt_pkg::JT_FTOP;
                c.pop_loop = is_loop;
                c.pop_func = !is_loop;
                if (is_loop ? stat.loop_cross : stat.func_cross) begin
                    err_next   = is_loop ? bmt_pkg::ERR_LOOP_CROSS : bmt_pkg::ERR_FUNC_CROSS;
                    state_next = S_HERR;
                end else begin
                    hdone = 1'b1;
                end
            end
            S_HERR: begin
                c.emit    = 1'b1;
                c.kind    = bmt_pkg::KIND_ERR;
                c.err     = err_reg;
                c.idx_sel = bmt_pkg::IDX_POS;
                hdone     = 1'b1;
            end
            S_FIN: begin
                fin_next = 1'b1;
                if (!stat.seen) begin
                    c.emit     = 1'b1;
                    c.kind     = bmt_pkg::KIND_ERR;
                    c.err      = bmt_pkg::ERR_EMPTY;
                    c.idx_sel  = bmt_pkg::IDX_ZERO;
                    c.last     = 1'b1;
                    c.clear    = 1'b1;
                    state_next = S_IDLE;
                end else if (stat.zl != 2'd0) begin
                    held_next    = stat.zl;
                    c.zl_wr      = 1'b1;
                    c.cur_ld     = 1'b1;
                    c.cur_sel    = bmt_pkg::CUR_OPEN;
                    ret_res_next = 1'b1;
                    state_next   = S_DISP;
                end else begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (stat.run_busy) begin
                    c.emit    = 1'b1;
                    c.op      = bmt_pkg::OP_RUN_BASE + {4'd0, stat.run_op[1:0]};
                    c.rep_run = 1'b1;
                    c.run_clr = 1'b1;
                end
                state_next = S_UNLW;
            end
            S_UNLW: state_next = S_UNL;
            S_UNL: begin
                if (!stat.loop_empty) begin
                    c.emit     = 1'b1;
                    c.kind     = bmt_pkg::KIND_ERR;
                    c.err      = bmt_pkg::ERR_OPEN_LOOP;
                    c.idx_sel  = bmt_pkg::IDX_LTOP;
                    c.pop_loop = 1'b1;
                    state_next = S_UNLW;
                end else begin
                    state_next = S_UNFW;
                end
            end
            S_UNFW: state_next = S_UNF;
            S_UNF: begin
                if (!stat.func_empty) begin
                    c.emit     = 1'b1;
                    c.kind     = bmt_pkg::KIND_ERR;
                    c.err      = bmt_pkg::ERR_OPEN_FUNC;
                    c.idx_sel  = bmt_pkg::IDX_FTOP;
                    c.pop_func = 1'b1;
                    state_next = S_UNFW;
                end else begin
                    state_next = S_ENDP;
                end
            end
            S_ENDP: begin
                c.emit     = 1'b1;
                c.op       = bmt_pkg::OP_END_PROGRAM;
                c.last     = 1'b1;
                c.clear    = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase

        // return from bracket/operator handling
        if (hdone) begin
            if (!ret_res_reg) begin
                state_next = after_st;
            end else if (held_reg == 2'd2) begin
                held_next  = 2'd0;
                c.cur_ld   = 1'b1;
                c.cur_sel  = bmt_pkg::CUR_DEC;
                state_next = S_DISP;
            end else begin
                state_next = fin_reg ? S_FLUSH : S_RUNCHK;
            end
        end

        // hold everything while the result register is full
        if (c.emit && !stat.out_free) begin
            c            = '0;
            state_next   = state_reg;
            held_next    = held_reg;
            ret_res_next = ret_res_reg;
            fin_next     = fin_reg;
            err_next     = err_reg;
        end
    end

    assign cmd = c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            held_reg    <= '0;
            ret_res_reg <= 1'b0;
            fin_reg     <= 1'b0;
            err_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            held_reg    <= held_next;
            ret_res_reg <= ret_res_next;
            fin_reg     <= fin_next;
            err_reg     <= err_next;
        end
    end

endmodule

### hdl/bracket_matching_tokenizer.sv
// Top level of the bracket matching tokenizer: ports, word packing and checks.
//
//  channel | dir | handshake            | carries
//  s_      | in  | s_tvalid / s_tready  | one source byte, char flag, end of program
//  m_      | out | m_tvalid / m_tready  | one record: instruction, patch or error report
//  cfg_    | in  | cfg_valid/cfg_ready  | register write: 0 dialect, 1 optimization level
//
// Sequencing: an input word passes the sequencer states (feed, run check, main, dispatch)
// plus a state per extra record; a closing bracket adds a patch and an instruction state.
// End of program reports each open bracket after a wait for the registered stack read.
// Reset (aresetn low, synchronous) clears control and program state; stack memories are
// not cleared, since an entry is only read after it was pushed.
// A stalled m_ side holds the sequencer; cfg_ is always ready.
module bracket_matching_tokenizer #(
    parameter int STACK_DEPTH = bmt_pkg::STACK_DEPTH,
    parameter int INDEX_BITS  = bmt_pkg::INDEX_BITS,
    parameter int COUNT_BITS  = bmt_pkg::COUNT_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // source_char
    input  logic               s_tuser,   // char_valid
    input  logic               s_tlast,   // end_of_source
    output logic               m_tvalid,
    input  logic               m_tready,
    // record_kind, op_code, instr_index, jump_target, repeat_count, error_code, syntax_ok
    output logic [TDATA_W-1:0] m_tdata,
    output logic               m_tlast,   // last
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [1:0]         cfg_data
);

    localparam int FIELDS_W = 13 + 2 * INDEX_BITS + COUNT_BITS;
    localparam int TDATA_W  = ((FIELDS_W + 7) / 8) * 8;
    localparam int OK_POS   = FIELDS_W - 1;

    bmt_pkg::cmd_t         cmd;
    bmt_pkg::stat_t        stat;
    logic                  accept;
    logic [1:0]            o_kind;
    logic [5:0]            o_op;
    logic [INDEX_BITS-1:0] o_idx, o_jt;
    logic [COUNT_BITS-1:0] o_rep;
    logic [3:0]            o_err;
    logic                  o_ok;

    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    bmt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .stat     (stat),
        .cmd      (cmd),
        .in_ready (s_tready)
    );

    bmt_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .INDEX_BITS  (INDEX_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .in_cv     (s_tuser),
        .in_char   (s_tdata),
        .in_eos    (s_tlast),
        .cfg_we    (cfg_valid),
        .cfg_idx   (cfg_index),
        .cfg_val   (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_kind  (o_kind),
        .out_op    (o_op),
        .out_idx   (o_idx),
        .out_jt    (o_jt),
        .out_rep   (o_rep),
        .out_err   (o_err),
        .out_ok    (o_ok),
        .out_last  (m_tlast)
    );

    assign m_tdata = TDATA_W'({o_ok, o_err, o_rep, o_jt, o_idx, o_op, o_kind});

`ifndef ASSERT_OFF
    // a word is worked off before the next one is taken
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while busy");

    // the program closes with end-of-program or the empty-source report
    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[1:0] == bmt_pkg::KIND_INSTR ||
                                   m_tdata[1:0] == bmt_pkg::KIND_ERR))
        else $error("last record is a patch");

    // an error report always clears syntax_ok
    a_err_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1:0] == bmt_pkg::KIND_ERR) |-> !m_tdata[OK_POS])
        else $error("error report with syntax_ok set");
`endif

endmodule

### tb/bracket_matching_tokenizer_check.sv
// Checker for the bracket matching tokenizer: predicts records and compares them.
module bracket_matching_tokenizer_check
    import bmt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [1:0]  cfg_data,
    output int          fail_count,
    output int          records_waiting
);

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  op;
        logic [15:0] idx;
        logic [15:0] jt;
        logic [7:0]  rep;
        logic [3:0]  err;
        logic        ok;
        logic        last;
    } record_t;

    record_t     record_q[$];
    logic [1:0]  dialect;
    logic [1:0]  opt_level;
    logic [5:0]  run_op;
    logic [7:0]  run_count;
    logic [1:0]  zero_seen;
    logic        shared_pending;
    logic [15:0] instr_cnt;
    logic [15:0] loop_stk [STACK_DEPTH];
    logic [15:0] func_stk [STACK_DEPTH];
    int          loop_depth;
    int          func_depth;
    logic        ok_flag;
    logic        seen_byte;
    int          step_records;

    assign records_waiting = record_q.size();

    function automatic void clear_program();
        run_op = 0;
        run_count = 0;
        zero_seen = 0;
        shared_pending = 0;
        instr_cnt = 0;
        loop_depth = 0;
        func_depth = 0;
        ok_flag = 1;
        seen_byte = 0;
    endfunction

    function automatic void add_record(logic [1:0] kind, logic [5:0] op, logic [15:0] idx,
                                       logic [15:0] jt, logic [7:0] rep, logic [3:0] err,
                                       logic last);
        record_t r;
        if (step_records >= MAX_RESULTS) return;
        r = '{kind, op, idx, jt, rep, err, ok_flag, last};
        record_q.push_back(r);
        step_records++;
    endfunction

    function automatic void add_instr(logic [5:0] op, logic [15:0] jt, logic [7:0] rep,
                                      logic last);
        add_record(KIND_INSTR, op, instr_cnt, jt, rep, 4'd0, last);
        instr_cnt = instr_cnt + 16'd1;
    endfunction

    function automatic void add_error(logic [3:0] err, logic [15:0] pos, logic last);
        ok_flag = 0;
        add_record(KIND_ERR, OP_LEFT, pos, 16'd0, 8'd1, err, last);
    endfunction

    // operator decode per dialect; debug operators only at level 0
    function automatic logic [5:0] decode_char(logic [7:0] c);
        logic dbg;
        dbg = (opt_level == 2'd0);
        case (c)
            "<": return OP_LEFT;
            ">": return OP_RIGHT;
            "+": return OP_INC;
            "-": return OP_DEC;
            ".": return OP_OUT;
            ",": return OP_IN;
            "[": return OP_OPEN_LOOP;
            "]": return OP_CLOSE_LOOP;
            default: ;
        endcase
        if (dialect == DIA_THREAD) begin
            case (c)
                "{": return OP_FORK;
                "}": return OP_JOIN;
                "!": return OP_TERM;
                "(": return OP_OPEN_FUNC;
                ")": return OP_CLOSE_FUNC;
                "*": return OP_CALL;
                "&": return OP_PUSH;
                "^": return OP_POP;
                "%": return OP_SWAP;
                "~": return OP_SWITCH;
                ":": return OP_DEC_WRITE;
                ";": return OP_DEC_READ;
                default: ;
            endcase
            if (dbg) begin
                case (c)
                    "M": return OP_DUMP_SIMPLE;
                    "D": return OP_DUMP_MEM;
                    "F": return OP_DUMP_FSTACK;
                    "E": return OP_DUMP_FDEFS;
                    "S": return OP_DUMP_STACK;
                    "H": return OP_DUMP_SHARED;
                    "T": return OP_DUMP_THREAD;
                    "#": return OP_PRAGMA;
                    default: ;
                endcase
            end
        end else if (dialect == DIA_PROC) begin
            case (c)
                "(": return OP_OPEN_FUNC;
                ")": return OP_CLOSE_FUNC;
                ":": return OP_CALL;
                default: ;
            endcase
            if (dbg) begin
                case (c)
                    "M": return OP_DUMP_SIMPLE;
                    "D": return OP_DUMP_MEM;
                    "F": return OP_DUMP_FSTACK;
                    "E": return OP_DUMP_FDEFS;
                    default: ;
                endcase
            end
        end else if (dialect == DIA_FORK) begin
            if (c == "Y") return OP_FORK;
            if (dbg && c == "M") return OP_DUMP_SIMPLE;
            if (dbg && c == "D") return OP_DUMP_MEM;
            if (dbg && c == "T") return OP_DUMP_THREAD;
        end else if (dbg) begin
            if (c == "#" || c == "M") return OP_DUMP_SIMPLE;
            if (c == "D") return OP_DUMP_MEM;
        end
        return OP_NONE;
    endfunction

    function automatic void dispatch_op(logic [5:0] op);
        logic [15:0] pos;
        logic [15:0] top;
        pos = instr_cnt;
        if (op == OP_OPEN_LOOP) begin
            add_instr(op, 16'd0, 8'd1, 1'b0);
            if (loop_depth < STACK_DEPTH) loop_stk[loop_depth++] = pos;
            else add_error(ERR_OVERFLOW, pos, 1'b0);
        end else if (op == OP_OPEN_FUNC) begin
            add_instr(op, 16'd0, 8'd1, 1'b0);
            if (func_depth < STACK_DEPTH) func_stk[func_depth++] = pos;
            else add_error(ERR_OVERFLOW, pos, 1'b0);
        end else if (op == OP_CLOSE_LOOP) begin
            if (loop_depth == 0) begin
                add_error(ERR_STRAY_LOOP, pos, 1'b0);
                return;
            end
            top = loop_stk[loop_depth-1];
            add_record(KIND_PATCH, OP_OPEN_LOOP, top, pos, 8'd1, 4'd0, 1'b0);
            add_instr(op, top, 8'd1, 1'b0);
            loop_depth--;
            if (func_depth > 0 && top < func_stk[func_depth-1])
                add_error(ERR_LOOP_CROSS, pos, 1'b0);
        end else if (op == OP_CLOSE_FUNC) begin
            if (func_depth == 0) begin
                add_error(ERR_STRAY_FUNC, pos, 1'b0);
                return;
            end
            top = func_stk[func_depth-1];
            add_record(KIND_PATCH, OP_OPEN_FUNC, top, pos, 8'd1, 4'd0, 1'b0);
            add_instr(op, top, 8'd1, 1'b0);
            func_depth--;
            if (loop_depth > 0 && top < loop_stk[loop_depth-1])
                add_error(ERR_FUNC_CROSS, pos, 1'b0);
        end else if (op == OP_SWITCH) begin
            shared_pending = 1;
        end else if (shared_pending) begin
            shared_pending = 0;
            if (op == OP_PUSH || op == OP_POP || op == OP_SWAP)
                add_instr(OP_SHARED_PUSH + (op - OP_PUSH), 16'd0, 8'd1, 1'b0);
            else
                add_error(ERR_BAD_SWITCH, pos, 1'b0);
        end else if (op == OP_PRAGMA) begin
            add_error(ERR_OVERFLOW, pos, 1'b0);
        end else if (opt_level >= 2'd2 && op <= OP_DEC) begin
            run_op = op;
            run_count = 8'd1;
        end else begin
            add_instr(op, 16'd0, 8'd1, 1'b0);
        end
    endfunction

    function automatic void flush_run();
        if (run_count != 0) begin
            add_instr(OP_RUN_BASE + {4'd0, run_op[1:0]}, 16'd0, run_count, 1'b0);
            run_count = 0;
        end
    endfunction

    // "[" or "[-" held back while waiting for a set-zero pattern
    function automatic void release_zero();
        logic [1:0] held;
        held = zero_seen;
        zero_seen = 0;
        if (held >= 2'd1) dispatch_op(OP_OPEN_LOOP);
        if (held >= 2'd2) dispatch_op(OP_DEC);
    endfunction

    function automatic void take_char(logic [7:0] c);
        logic [5:0] op;
        op = decode_char(c);
        if (zero_seen == 2'd1 && op == OP_DEC) begin
            zero_seen = 2'd2;
            return;
        end
        if (zero_seen == 2'd2 && op == OP_CLOSE_LOOP) begin
            zero_seen = 0;
            add_instr(OP_SET_ZERO, 16'd0, 8'd1, 1'b0);
            return;
        end
        if (zero_seen != 0) release_zero();
        if (run_count != 0) begin
            if (op == run_op && run_count != 8'hFF) begin
                run_count++;
                return;
            end
            flush_run();
        end
        if (op == OP_NONE) return;
        if (opt_level >= 2'd2 && op == OP_OPEN_LOOP) begin
            zero_seen = 2'd1;
            return;
        end
        dispatch_op(op);
    endfunction

    function automatic void end_program();
        if (!seen_byte) begin
            add_error(ERR_EMPTY, 16'd0, 1'b1);
            clear_program();
            return;
        end
        release_zero();
        flush_run();
        while (loop_depth > 0) begin
            loop_depth--;
            add_error(ERR_OPEN_LOOP, loop_stk[loop_depth], 1'b0);
        end
        while (func_depth > 0) begin
            func_depth--;
            add_error(ERR_OPEN_FUNC, func_stk[func_depth], 1'b0);
        end
        add_instr(OP_END_PROGRAM, 16'd0, 8'd1, 1'b1);
        clear_program();
    endfunction

    always @(posedge aclk) begin
        record_t got;
        record_t want;
        if (!aresetn) begin
            dialect = DIA_THREAD;
            opt_level = 2'd1;
            clear_program();
            record_q.delete();
            fail_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_DIALECT) dialect = cfg_data;
                else opt_level = cfg_data;
            end
            // compare outgoing word before queuing new predictions
            if (m_tvalid && m_tready) begin
                got = '{m_tdata[1:0], m_tdata[7:2], m_tdata[23:8], m_tdata[39:24],
                        m_tdata[47:40], m_tdata[51:48], m_tdata[52], m_tlast};
                if (record_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected word %h last %b", m_tdata, m_tlast);
                end else begin
                    want = record_q.pop_front();
                    if (got != want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: kind %0d/%0d op %0d/%0d idx %0d/%0d jt %0d/%0d rep %0d/%0d err %0d/%0d ok %0d/%0d last %0d/%0d (exp/got)",
                                     want.kind, got.kind, want.op, got.op, want.idx, got.idx,
                                     want.jt, got.jt, want.rep, got.rep, want.err, got.err,
                                     want.ok, got.ok, want.last, got.last);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                step_records = 0;
                if (s_tuser) begin
                    seen_byte = 1;
                    take_char(s_tdata);
                end
                if (s_tlast) end_program();
            end
        end
    end

endmodule

### tb/bracket_matching_tokenizer_test.sv
// Testbench top for the bracket matching tokenizer: stimulus, handshake pacing, verdict.
module bracket_matching_tokenizer_test;
    import bmt_pkg::*;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [7:0]  s_tdata = 0;   // source_char
    logic        s_tuser = 0;   // char_valid
    logic        s_tlast = 0;   // end_of_source
    logic        m_tvalid;
    logic        m_tready = 0;
    // record_kind, op_code, instr_index, jump_target, repeat_count, error_code, syntax_ok
    logic [55:0] m_tdata;
    logic        m_tlast;       // last
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic        cfg_index = CFG_DIALECT;
    logic [1:0]  cfg_data = 0;

    int          fail_count;
    int          records_waiting;
    int          cycle_count = 0;
    bit          idle_on = 1;     // random gaps on both sides
    int          hold_cycles = 0; // long receiver hold-off, counted down below
    int          ready_wait = 0;

    // operator alphabet covering all dialects, plus debug letters
    string       op_chars = "<>+-.,[]()*{}!&^%~;:#MTFSEDHY";

    bracket_matching_tokenizer dut (.*);

    bracket_matching_tokenizer_check checker_i (.*);

    initial forever #1 aclk = ~aclk;

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    always @(posedge aclk) begin
        if (cycle_count > 400000) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: per-word random stall, plus an optional long hold-off
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            m_tready <= 0;
        end else begin
            if (m_tvalid && m_tready)
                ready_wait = idle_on ? $urandom_range(0, 5) : 0;
            if (ready_wait > 0) begin
                ready_wait = ready_wait - 1;
                m_tready <= 0;
            end else begin
                m_tready <= 1;
            end
        end
    end

    task automatic send_word(bit cv, logic [7:0] ch, bit eos);
        int gap;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= cv;
        s_tdata  <= ch;
        s_tlast  <= eos;
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 0;
        while (records_waiting != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    // register writes only once the block has drained
    task automatic write_reg(logic idx, logic [1:0] val);
        wait_drained();
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(negedge aclk); while (!cfg_ready);
        @(posedge aclk);
        cfg_valid <= 0;
    endtask

    task automatic send_text(string txt);
        for (int i = 0; i < txt.len(); i++)
            send_word(1, txt[i], i == txt.len() - 1);
    endtask

    // mostly well-formed programs with random content, some noise and stray brackets
    task automatic random_program(int len);
        int  loops;
        int  funcs;
        int  r;
        int  n;
        byte c;
        loops = 0;
        funcs = 0;
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 10 && loops < 6) begin
                send_word(1, "[", 0);
                loops++;
            end else if (r < 18 && loops > 0) begin
                send_word(1, "]", 0);
                loops--;
            end else if (r < 23 && funcs < 4) begin
                send_word(1, "(", 0);
                funcs++;
            end else if (r < 28 && funcs > 0) begin
                send_word(1, ")", 0);
                funcs--;
            end else if (r < 33) begin
                send_word(1, "[", 0);
                send_word(1, "-", 0);
                send_word(1, "]", 0);
            end else if (r < 45) begin
                c = op_chars[$urandom_range(0, 3)];
                n = $urandom_range(1, 6);
                repeat (n) send_word(1, c, 0);
            end else if (r < 50) begin
                send_word(1, "~", 0);
                send_word(1, op_chars[$urandom_range(14, 17)], 0);
            end else if (r < 88) begin
                send_word(1, op_chars[$urandom_range(0, op_chars.len() - 1)], 0);
            end else if (r < 96) begin
                send_word(1, $urandom_range(0, 255), 0);
            end else begin
                send_word(0, $urandom_range(0, 255), 0);
            end
        end
        if ($urandom_range(0, 9) < 7) begin
            while (loops > 0) begin send_word(1, "]", 0); loops--; end
            while (funcs > 0) begin send_word(1, ")", 0); funcs--; end
        end
        if ($urandom_range(0, 1)) send_word(1, op_chars[$urandom_range(0, 7)], 1);
        else send_word(0, $urandom_range(0, 255), 1);
    endtask

    initial begin
        logic [1:0] settings [10][2];
        settings = '{'{DIA_THREAD, 2'd0}, '{DIA_THREAD, 2'd1}, '{DIA_THREAD, 2'd2},
                     '{DIA_PROC, 2'd0}, '{DIA_PROC, 2'd2}, '{DIA_FORK, 2'd0},
                     '{DIA_FORK, 2'd2}, '{2'd3, 2'd0}, '{2'd3, 2'd1}, '{2'd3, 2'd3}};
        repeat (12) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: empty program, then thread dialect with debug ops and pragma
        send_word(0, 8'hFF, 1);
        write_reg(CFG_OPT, 2'd0);
        send_text("[(])~&~x#1M)]~[~^");
        // overflow of the function stack and unclosed functions
        send_text("(((((((((((((((((");
        // folding: set-zero, broken pattern, and a run past the count limit
        write_reg(CFG_OPT, 2'd2);
        send_text("[-][-x]++<<>[");
        repeat (300) send_word(1, "+", 0);
        send_word(1, "-", 1);

        for (int s = 0; s < 10; s++) begin
            write_reg(CFG_DIALECT, settings[s][0]);
            write_reg(CFG_OPT, settings[s][1]);
            idle_on = (s != 4);
            if (s == 2) begin
                // hold the receiver off while input keeps coming, so the block backs up
                hold_cycles = 400;
                random_program(40);
            end
            random_program($urandom_range(8, 20));
            if (s == 6) wait_drained();   // sender pauses until all records are out
            random_program($urandom_range(8, 20));
        end

        wait_drained();
        if (fail_count == 0 && records_waiting == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
